FILE: src/assert_macros.svh
// Assertion macros for the rotator checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked outside reset.
`define EVR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rotator check failed");

// Implication checked on every edge, reset included.
`define EVR_ASSERT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("rotator check failed");

`endif

FILE: src/evr_pkg.sv
package evr_pkg;

  localparam int TRIG_ITERATIONS = 16;
  localparam int CORDIC_MAX = 24;
  localparam int NITER = (TRIG_ITERATIONS > CORDIC_MAX) ? CORDIC_MAX : TRIG_ITERATIONS;
  localparam int IW = $clog2(CORDIC_MAX);

  // CORDIC datapath width, trig result width, vector width.
  localparam int CW = 34;
  localparam int TW = 32;
  localparam int VW = 35;
  localparam int PW = VW + TW;

  localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;

  typedef struct packed {
    logic                 cmd;
    logic signed [TW-1:0] cx;
    logic signed [TW-1:0] sx;
    logic signed [TW-1:0] cy;
    logic signed [TW-1:0] sy;
    logic signed [TW-1:0] cz;
    logic signed [TW-1:0] sz;
  } side_t;

  function automatic logic signed [CW-1:0] atan_val(input logic [IW-1:0] i);
    logic signed [CW-1:0] v;
    case (i)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10680862;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/euler_vector_rotator_core.sv
// Throughput: one request per cycle; the whole pipeline advances together and
// freezes only while a finished result is held by out_stall.
// Reset: synchronous, active low rst_n clears every valid bit; payload is not reset.
module euler_vector_rotator_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_cmd,
  input  logic signed [31:0]  in_vec_x,
  input  logic signed [31:0]  in_vec_y,
  input  logic signed [31:0]  in_vec_z,
  input  logic signed [15:0]  in_angle_x,
  input  logic signed [15:0]  in_angle_y,
  input  logic signed [15:0]  in_angle_z,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z
);

  localparam int N  = evr_pkg::NITER;
  localparam int CW = evr_pkg::CW;
  localparam int VW = evr_pkg::VW;
  localparam int TW = evr_pkg::TW;

  // Data that rides alongside the CORDIC stages.
  typedef struct packed {
    logic                 cmd;
    logic [2:0]           flip;
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
    logic signed [VW-1:0] vz;
  } carry_t;

  // The whole pipeline moves as one; it holds only when the output register
  // is full and the consumer stalls.
  logic en;
  assign in_stall = out_valid & out_stall;
  assign en = ~in_stall;

  // Stage 0: angle reduction. The inverse negates the angle; angles in the
  // two outer quadrants are moved by pi and the results negated later.
  logic [15:0] ang [3];
  logic [15:0] aneg [3];
  logic [2:0]  flip_nxt;
  logic signed [CW-1:0] z0_nxt [3];

  assign ang[0] = in_angle_x;
  assign ang[1] = in_angle_y;
  assign ang[2] = in_angle_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      aneg[k] = in_cmd ? (16'h0000 - ang[k]) : ang[k];
      flip_nxt[k] = aneg[k][15] ^ aneg[k][14];
      z0_nxt[k] = CW'($signed({aneg[k][15] ^ flip_nxt[k], aneg[k][14:0], 16'h0000}));
    end
  end

  logic                 v_r [N+1];
  carry_t               carry_r [N+1];
  logic signed [CW-1:0] cx_r [N+1][3];
  logic signed [CW-1:0] cy_r [N+1][3];
  logic signed [CW-1:0] cz_r [N+1][3];

  always_ff @(posedge clk) begin
    if (en) begin
      carry_r[0].cmd  <= in_cmd;
      carry_r[0].flip <= flip_nxt;
      carry_r[0].vx   <= VW'(in_vec_x);
      carry_r[0].vy   <= VW'(in_vec_y);
      carry_r[0].vz   <= VW'(in_vec_z);
      for (int k = 0; k < 3; k++) begin
        cx_r[0][k] <= evr_pkg::CORDIC_K;
        cy_r[0][k] <= '0;
        cz_r[0][k] <= z0_nxt[k];
      end
    end
  end

  // CORDIC stages: one iteration per stage for each of the three angles.
  genvar gi, gk;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cordic
      for (gk = 0; gk < 3; gk++) begin : g_lane
        evr_cordic_lane u_lane (
          .clk  (clk),
          .en   (en),
          .idx  (evr_pkg::IW'(gi)),
          .x_in (cx_r[gi][gk]),
          .y_in (cy_r[gi][gk]),
          .z_in (cz_r[gi][gk]),
          .x_r  (cx_r[gi+1][gk]),
          .y_r  (cy_r[gi+1][gk]),
          .z_r  (cz_r[gi+1][gk])
        );
      end
      always_ff @(posedge clk) begin
        if (en) begin
          carry_r[gi+1] <= carry_r[gi];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= N; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 0; k < N; k++) begin
        v_r[k+1] <= v_r[k];
      end
    end
  end

  // Fix stage: undo the quadrant move and narrow the trig values to Q2.30.
  logic signed [TW-1:0] cos_nxt [3];
  logic signed [TW-1:0] sin_nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (carry_r[N].flip[k]) begin
        cos_nxt[k] = TW'(-cx_r[N][k]);
        sin_nxt[k] = TW'(-cy_r[N][k]);
      end else begin
        cos_nxt[k] = cx_r[N][k][TW-1:0];
        sin_nxt[k] = cy_r[N][k][TW-1:0];
      end
    end
  end

  logic                 fv_r;
  evr_pkg::side_t       fside_r;
  logic signed [VW-1:0] fvx_r, fvy_r, fvz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      fside_r.cmd <= carry_r[N].cmd;
      fside_r.cx  <= cos_nxt[0];
      fside_r.sx  <= sin_nxt[0];
      fside_r.cy  <= cos_nxt[1];
      fside_r.sy  <= sin_nxt[1];
      fside_r.cz  <= cos_nxt[2];
      fside_r.sz  <= sin_nxt[2];
      fvx_r <= carry_r[N].vx;
      fvy_r <= carry_r[N].vy;
      fvz_r <= carry_r[N].vz;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (en) begin
      fv_r <= v_r[N];
    end
  end

  // Three plane rotations. Each takes (p, q) to (p*c + q*s, q*c - p*s) and
  // carries the third component along. Forward runs z, y, x; inverse x, y, z.
  logic                 rv1, rv2, rv3;
  evr_pkg::side_t       rs1, rs2, rs3;
  logic signed [VW-1:0] a1, b1, w1, a2, b2, w2, a3, b3, w3;

  logic signed [VW-1:0] p1, q1, pw1, p2, q2, pw2, p3, q3, pw3;
  logic signed [TW-1:0] c1, s1, c3, s3;

  always_comb begin
    if (fside_r.cmd) begin
      p1 = fvy_r; q1 = fvz_r; pw1 = fvx_r;
      c1 = fside_r.cx; s1 = fside_r.sx;
    end else begin
      p1 = fvx_r; q1 = fvy_r; pw1 = fvz_r;
      c1 = fside_r.cz; s1 = fside_r.sz;
    end
    if (rs1.cmd) begin
      p2 = b1; q2 = w1; pw2 = a1;
    end else begin
      p2 = w1; q2 = a1; pw2 = b1;
    end
    if (rs2.cmd) begin
      p3 = b2; q3 = w2; pw3 = a2;
      c3 = rs2.cz; s3 = rs2.sz;
    end else begin
      p3 = w2; q3 = a2; pw3 = b2;
      c3 = rs2.cx; s3 = rs2.sx;
    end
  end

  evr_rot u_rot1 (
    .clk(clk), .rst_n(rst_n), .en(en), .valid_in(fv_r), .side_in(fside_r),
    .p(p1), .q(q1), .pass_in(pw1), .c(c1), .s(s1),
    .valid_r(rv1), .side_r(rs1), .r1_r(a1), .r2_r(b1), .pass_r(w1)
  );

  evr_rot u_rot2 (
    .clk(clk), .rst_n(rst_n), .en(en), .valid_in(rv1), .side_in(rs1),
    .p(p2), .q(q2), .pass_in(pw2), .c(rs1.cy), .s(rs1.sy),
    .valid_r(rv2), .side_r(rs2), .r1_r(a2), .r2_r(b2), .pass_r(w2)
  );

  evr_rot u_rot3 (
    .clk(clk), .rst_n(rst_n), .en(en), .valid_in(rv2), .side_in(rs2),
    .p(p3), .q(q3), .pass_in(pw3), .c(c3), .s(s3),
    .valid_r(rv3), .side_r(rs3), .r1_r(a3), .r2_r(b3), .pass_r(w3)
  );

  // Output stage: put the components back in x, y, z order and saturate.
  function automatic logic signed [31:0] sat32(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] hi, lo;
    hi = VW'(32'sh7fffffff);
    lo = VW'(-33'sd2147483648);
    if (v > hi) return 32'sh7fffffff;
    if (v < lo) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic signed [VW-1:0] ox, oy, oz;
  logic                 out_valid_r;
  logic signed [31:0]   out_x_r, out_y_r, out_z_r;

  always_comb begin
    if (rs3.cmd) begin
      ox = a3; oy = b3; oz = w3;
    end else begin
      ox = w3; oy = a3; oz = b3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r <= sat32(ox);
      out_y_r <= sat32(oy);
      out_z_r <= sat32(oz);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= rv3;
    end
  end

  assign out_valid = out_valid_r;
  assign out_x = out_x_r;
  assign out_y = out_y_r;
  assign out_z = out_z_r;

endmodule

FILE: src/evr_cordic_lane.sv
module evr_cordic_lane (
  input  logic                           clk,
  input  logic                           en,
  input  logic [evr_pkg::IW-1:0]         idx,
  input  logic signed [evr_pkg::CW-1:0]  x_in,
  input  logic signed [evr_pkg::CW-1:0]  y_in,
  input  logic signed [evr_pkg::CW-1:0]  z_in,
  output logic signed [evr_pkg::CW-1:0]  x_r,
  output logic signed [evr_pkg::CW-1:0]  y_r,
  output logic signed [evr_pkg::CW-1:0]  z_r
);

  logic signed [evr_pkg::CW-1:0] x_nxt, y_nxt, z_nxt, xs, ys;

  always_comb begin
    xs = x_in >>> idx;
    ys = y_in >>> idx;
    if (!z_in[evr_pkg::CW-1]) begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - evr_pkg::atan_val(idx);
    end else begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + evr_pkg::atan_val(idx);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

endmodule

FILE: src/evr_rot.sv
module evr_rot (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           valid_in,
  input  evr_pkg::side_t                 side_in,
  input  logic signed [evr_pkg::VW-1:0]  p,
  input  logic signed [evr_pkg::VW-1:0]  q,
  input  logic signed [evr_pkg::VW-1:0]  pass_in,
  input  logic signed [evr_pkg::TW-1:0]  c,
  input  logic signed [evr_pkg::TW-1:0]  s,
  output logic                           valid_r,
  output evr_pkg::side_t                 side_r,
  output logic signed [evr_pkg::VW-1:0]  r1_r,
  output logic signed [evr_pkg::VW-1:0]  r2_r,
  output logic signed [evr_pkg::VW-1:0]  pass_r
);

  localparam logic signed [evr_pkg::PW:0] HALF = (evr_pkg::PW+1)'(1) <<< 29;

  logic                          va_r;
  evr_pkg::side_t                side_a_r;
  logic signed [evr_pkg::VW-1:0] pass_a_r;
  logic signed [evr_pkg::PW-1:0] pc_r, qs_r, qc_r, ps_r;
  logic signed [evr_pkg::PW:0]   rpc, rqs, rqc, rps;
  logic signed [evr_pkg::PW:0]   r1_nxt, r2_nxt;

  // First stage: four products, registered.
  always_ff @(posedge clk) begin
    if (en) begin
      pc_r     <= evr_pkg::PW'(p) * evr_pkg::PW'(c);
      qs_r     <= evr_pkg::PW'(q) * evr_pkg::PW'(s);
      qc_r     <= evr_pkg::PW'(q) * evr_pkg::PW'(c);
      ps_r     <= evr_pkg::PW'(p) * evr_pkg::PW'(s);
      side_a_r <= side_in;
      pass_a_r <= pass_in;
    end
  end

  // Second stage: round each product to Q16.16 on its own, then combine.
  always_comb begin
    rpc = ((evr_pkg::PW+1)'(pc_r) + HALF) >>> 30;
    rqs = ((evr_pkg::PW+1)'(qs_r) + HALF) >>> 30;
    rqc = ((evr_pkg::PW+1)'(qc_r) + HALF) >>> 30;
    rps = ((evr_pkg::PW+1)'(ps_r) + HALF) >>> 30;
    r1_nxt = rpc + rqs;
    r2_nxt = rqc - rps;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_r   <= r1_nxt[evr_pkg::VW-1:0];
      r2_r   <= r2_nxt[evr_pkg::VW-1:0];
      pass_r <= pass_a_r;
      side_r <= side_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r    <= 1'b0;
      valid_r <= 1'b0;
    end else if (en) begin
      va_r    <= valid_in;
      valid_r <= va_r;
    end
  end

endmodule

FILE: src/evr_checker.sv
`include "assert_macros.svh"

module evr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_x
);

  // Input is held back only by a full, stalled output.
  `EVR_ASSERT_IMP(a_stall_src, clk, rst_n, in_stall, out_valid && out_stall)
  // A stalled result stays visible.
  `EVR_ASSERT_IMP(a_hold, clk, rst_n, out_valid && out_stall, ##1 out_valid && $stable(out_x))
  // Reset empties the pipeline.
  `EVR_ASSERT_ALWAYS(a_reset, clk, $past(!rst_n), !out_valid)

endmodule

bind euler_vector_rotator_core evr_checker u_evr_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_x(out_x)
);

FILE: test/rotator_checker.sv
`timescale 1ns / 100ps

module rotator_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_cmd,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_vec_z,
  input  logic signed [15:0] in_angle_x,
  input  logic signed [15:0] in_angle_y,
  input  logic signed [15:0] in_angle_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_x,
  input  logic signed [31:0] out_y,
  input  logic signed [31:0] out_z,
  output int                 fail_count,
  output int                 pending
);

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  localparam logic CMD_INVERSE = 1'b1;

  vec_t rotated_q[$];

  // Sine and cosine of a binary angle in Q2.30, by rotation-mode CORDIC.
  task automatic sincos(input logic [15:0] ang, input logic negate,
                        output longint c, output longint s);
    logic [15:0] a;
    logic        flip;
    longint      x, y, z, nx, ny;
    a = negate ? 16'(17'h10000 - {1'b0, ang}) : ang;
    flip = (a[15:14] == 2'b01) || (a[15:14] == 2'b10);
    if (flip) a = a ^ 16'h8000;
    x = 652032874;
    y = 0;
    z = longint'($signed(a)) * 65536;
    for (int i = 0; i < evr_pkg::NITER; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z = z - longint'(evr_pkg::atan_val(i[evr_pkg::IW-1:0]));
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z = z + longint'(evr_pkg::atan_val(i[evr_pkg::IW-1:0]));
      end
      x = nx;
      y = ny;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint qmul(longint v, longint t);
    return (v * t + (longint'(1) << 29)) >>> 30;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  task automatic rotate(output vec_t r);
    longint cx, sx, cy, sy, cz, sz, a, b, c, rx, ry, rz, vx, vy, vz;
    logic   inv;
    inv = (in_cmd == CMD_INVERSE);
    vx = in_vec_x;
    vy = in_vec_y;
    vz = in_vec_z;
    sincos(in_angle_x, inv, cx, sx);
    sincos(in_angle_y, inv, cy, sy);
    sincos(in_angle_z, inv, cz, sz);
    if (!inv) begin
      a = qmul(vx, cz) + qmul(vy, sz);
      b = qmul(vy, cz) - qmul(vx, sz);
      rx = qmul(a, cy) - qmul(vz, sy);
      c = qmul(vz, cy) + qmul(a, sy);
      ry = qmul(b, cx) + qmul(c, sx);
      rz = qmul(c, cx) - qmul(b, sx);
    end else begin
      b = qmul(vy, cx) + qmul(vz, sx);
      c = qmul(vz, cx) - qmul(vy, sx);
      a = qmul(vx, cy) - qmul(c, sy);
      rz = qmul(c, cy) + qmul(vx, sy);
      rx = qmul(a, cz) + qmul(b, sz);
      ry = qmul(b, cz) - qmul(a, sz);
    end
    r.x = clamp32(rx);
    r.y = clamp32(ry);
    r.z = clamp32(rz);
  endtask

  task automatic report(input string what, input logic signed [31:0] got,
                        input logic signed [31:0] want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending = rotated_q.size();

  always @(posedge clk) begin
    vec_t r, e;
    if (!rst_n) fail_count = 0;
    if (rst_n && in_valid && !in_stall) begin
      rotate(r);
      rotated_q.push_back(r);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (rotated_q.size() == 0) begin
        $display("mismatch at %0t: result with no request outstanding", $realtime);
        fail_count++;
      end else begin
        e = rotated_q.pop_front();
        if (out_x !== e.x) report("out_x", out_x, e.x);
        if (out_y !== e.y) report("out_y", out_y, e.y);
        if (out_z !== e.z) report("out_z", out_z, e.z);
      end
    end
  end
endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_cmd;
  logic signed [31:0] in_vec_x;
  logic signed [31:0] in_vec_y;
  logic signed [31:0] in_vec_z;
  logic signed [15:0] in_angle_x;
  logic signed [15:0] in_angle_y;
  logic signed [15:0] in_angle_z;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  int                 fail_count;
  int                 pending;

  // Idle percentages for the sender and receiver, changed between phases.
  int send_idle_pct;
  int recv_idle_pct;
  // Cycles without any accepted request or result; the watchdog trips on this.
  int quiet_cycles;

  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_ITEMS = 1830;

  euler_vector_rotator_core u_top (.*);

  rotator_checker u_check (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The receiver stalls at random on every falling edge.
  always @(negedge clk) begin
    out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: ends the run if nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // Presents one request, holding it steady until the block accepts it.
  // A random gap may be inserted first, according to the sender idle rate.
  task automatic send(input logic cmd, input logic [31:0] vx, input logic [31:0] vy,
                      input logic [31:0] vz, input logic [15:0] ax,
                      input logic [15:0] ay, input logic [15:0] az);
    while ((send_idle_pct > 0) && ($urandom_range(99) < send_idle_pct)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_vec_x   <= vx;
    in_vec_y   <= vy;
    in_vec_z   <= vz;
    in_angle_x <= ax;
    in_angle_y <= ay;
    in_angle_z <= az;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Picks an angle that often lands on quadrant boundaries and the pi edge.
  function automatic logic [15:0] pick_angle();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'($urandom_range(3)) << 14;
      2: return (16'($urandom_range(3)) << 14) + 16'($urandom_range(2)) - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // Vectors are mostly full-range random, with a share of small values and of extreme values to hit saturation.
  function automatic logic [31:0] pick_vec();
    case ($urandom_range(7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed(16'($urandom)));
      default: return 32'($urandom);
    endcase
  endfunction

  initial begin
    in_valid   = 1'b0;
    in_cmd     = 1'b0;
    in_vec_x   = '0;
    in_vec_y   = '0;
    in_vec_z   = '0;
    in_angle_x = '0;
    in_angle_y = '0;
    in_angle_z = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests: both directions, the pi edge (which stays pi when
    // negated for the inverse), quadrant boundaries, and full-scale vectors
    // that force saturation.
    for (int d = 0; d < 2; d++) begin
      send(d[0], 32'h00010000, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0);
      send(d[0], 32'h00010000, 32'h00020000, 32'hfffd0000,
           16'h8000, 16'h8000, 16'h8000);
      send(d[0], 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
           16'h2000, 16'h2000, 16'h2000);
      send(d[0], 32'h80000000, 32'h80000000, 32'h80000000,
           16'h2000, 16'he000, 16'h6000);
      send(d[0], 32'h7fffffff, 32'h80000000, 32'h7fffffff,
           16'h4000, 16'hc000, 16'h7fff);
      send(d[0], 32'hffffffff, 32'h00000001, 32'h12345678,
           16'h3fff, 16'hbfff, 16'h8001);
      send(d[0], 32'h00000000, 32'h7fffffff, 32'h80000000,
           16'hffff, 16'h0001, 16'h4001);
      send(d[0], 32'haaaaaaaa, 32'h55555555, 32'hcccccccc,
           16'h5555, 16'haaaa, 16'hc000);
    end

    // Random phases: receiver stalls heavily with a light sender, then the
    // reverse, then full rate in both directions.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 0) begin
        send_idle_pct = 36;
        recv_idle_pct = 80;
      end else if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 80;
        recv_idle_pct = 36;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send(1'($urandom), pick_vec(), pick_vec(), pick_vec(),
           pick_angle(), pick_angle(), pick_angle());
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule

FILE: euler_vector_rotator_core.f
+incdir+src
src/evr_pkg.sv
src/evr_cordic_lane.sv
src/evr_rot.sv
src/euler_vector_rotator_core.sv
src/evr_checker.sv
test/rotator_checker.sv
test/testbench.sv
